/* rtl/uf2bfs_pkg.sv */
// Package for the UF2 block flash sequencer: item types, codes and fixed constants.
// Depends on nothing; every other file of the block but uf2bfs_ram imports it.
`timescale 1ns / 1ps

package uf2bfs_pkg;

    // Width of a flash offset and of the flash_bytes register
    localparam int OFF_W = 22;

    // Block magic words
    localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;

    // Flag bits that make a block skipped
    localparam int FLAG_NOT_MAIN_BIT  = 0;
    localparam int FLAG_CONTAINER_BIT = 12;

    // Register reset values
    localparam logic [31:0]      FLASH_BASE_RST      = 32'h1000_0000;
    localparam logic [OFF_W-1:0] FLASH_BYTES_RST     = 22'h20_0000;
    localparam logic [31:0]      ACCEPTED_FAMILY_RST = 32'hE48B_FF56;

    typedef enum logic [1:0] {
        CFG_FLASH_BASE      = 2'd0,
        CFG_FLASH_BYTES     = 2'd1,
        CFG_ACCEPTED_FAMILY = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_ERASE    = 3'd0,
        CMD_PROGRAM  = 3'd1,
        CMD_SKIPPED  = 3'd2,
        CMD_IGNORED  = 3'd3,
        CMD_ERROR    = 3'd4,
        CMD_IMAGE_OK = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MAGIC     = 3'd1,
        ERR_SIZE      = 3'd2,
        ERR_RANGE     = 3'd3,
        ERR_FAMILY    = 3'd4,
        ERR_ALIGN     = 3'd5,
        ERR_NO_BLOCKS = 3'd6,
        ERR_COUNT     = 3'd7
    } err_t;

    // Outcome of the stateless header checks, in priority order
    typedef enum logic [2:0] {
        CHK_OK     = 3'd0,
        CHK_MAGIC  = 3'd1,
        CHK_SKIP   = 3'd2,
        CHK_SIZE   = 3'd3,
        CHK_RANGE  = 3'd4,
        CHK_FAMILY = 3'd5
    } chk_t;

    typedef struct packed {
        logic        action;
        logic [31:0] magic_start0;
        logic [31:0] magic_start1;
        logic [31:0] magic_end;
        logic [31:0] flags;
        logic [31:0] target_addr;
        logic [31:0] payload_size;
        logic [31:0] num_blocks;
        logic [31:0] family_id;
    } hdr_t;

    typedef struct packed {
        cmd_t        command;
        logic [20:0] flash_offset;
        err_t        error_code;
        logic [15:0] blocks_written;
        logic        last;
    } res_t;

    // Check results handed from the check pipeline to the sequencer
    typedef struct packed {
        logic is_end;
        chk_t chk;
        logic align_ok;
        logic sector_ok;
    } s1_ctl_t;

    // Sequencer status fed back to the check pipeline
    typedef struct packed {
        logic take;
        logic clearing;
    } seq_stat_t;

endpackage

/* rtl/uf2bfs_if.sv */
// Channel interfaces of the UF2 block flash sequencer: header items, results, config writes.
// Depends on uf2bfs_pkg for the payload types.
`timescale 1ns / 1ps

interface uf2bfs_hdr_if import uf2bfs_pkg::*; ();
    logic valid;
    logic ready;
    hdr_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface uf2bfs_res_if import uf2bfs_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface uf2bfs_cfg_if import uf2bfs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/uf2bfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module uf2bfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/uf2bfs_check.sv */
// Input register and stateless header checks of the UF2 block flash sequencer.
// Depends on uf2bfs_pkg and uf2bfs_if; feeds uf2bfs_seq.
`timescale 1ns / 1ps

module uf2bfs_check
    import uf2bfs_pkg::*;
#(
    parameter int SECTOR_COUNT = 512,
    parameter int SECTOR_BYTES = 4096,
    parameter int PAGE_BYTES   = 256,
    localparam int IDX_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    uf2bfs_hdr_if.sink        hdr,
    input  logic [31:0]       flash_base,
    input  logic [OFF_W-1:0]  flash_bytes,
    input  logic [31:0]       accepted_family,
    input  seq_stat_t         stat,
    output logic              s1_valid,
    output s1_ctl_t           s1_ctl,
    output logic [31:0]       s1_nblocks,
    output logic [OFF_W-1:0]  s1_offset,
    output logic [OFF_W-1:0]  s1_sector_off,
    output logic [IDX_W-1:0]  s1_sector_idx
);

    // Reciprocals for exact division of an OFF_W-bit offset by each constant
    localparam int M_W    = OFF_W + 2;
    localparam int PROD_W = OFF_W + M_W;
    localparam int PG_L   = $clog2(PAGE_BYTES);
    localparam int PG_S   = OFF_W + PG_L;
    localparam int QP_W   = OFF_W - PG_L + 1;
    localparam longint unsigned PG_RECIP =
        ((64'd1 << PG_S) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [M_W-1:0] PG_MUL = M_W'(PG_RECIP);
    localparam int SC_L   = $clog2(SECTOR_BYTES);
    localparam int SC_S   = OFF_W + SC_L;
    localparam int QS_W   = OFF_W - SC_L + 1;
    localparam longint unsigned SC_RECIP =
        ((64'd1 << SC_S) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
    localparam logic [M_W-1:0] SC_MUL = M_W'(SC_RECIP);

    logic             s0_valid_reg, s0_valid_next;
    hdr_t             s0_hdr_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_end_reg;
    chk_t             s1_chk_reg;
    logic [31:0]      s1_nblocks_reg;
    logic [OFF_W-1:0] s1_offset_reg;
    logic [QP_W-1:0]  s1_qpage_reg;
    logic [QS_W-1:0]  s1_qsec_reg;

    logic             s0_adv, s1_free, hdr_take;
    logic             magic_bad, skip, size_bad, range_bad, family_bad;
    logic [32:0]      end_addr, limit_addr;
    logic [31:0]      off_full;
    logic [OFF_W-1:0] offset;
    logic [PROD_W-1:0] pg_prod, sc_prod;
    chk_t             chk;
    logic [OFF_W-1:0] page_base;
    logic [31:0]      sec_wide;

    // Handshake: take a new item when the input register empties and no sweep runs
    assign s1_free  = !s1_valid_reg || stat.take;
    assign s0_adv   = s0_valid_reg && s1_free;
    assign hdr.ready = (!s0_valid_reg || s0_adv) && !stat.clearing;
    assign hdr_take = hdr.valid && hdr.ready;

    // Stateless checks on the registered header
    assign magic_bad  = (s0_hdr_reg.magic_start0 != MAGIC_START0)
                     || (s0_hdr_reg.magic_start1 != MAGIC_START1)
                     || (s0_hdr_reg.magic_end != MAGIC_END);
    assign skip       = s0_hdr_reg.flags[FLAG_NOT_MAIN_BIT]
                     || s0_hdr_reg.flags[FLAG_CONTAINER_BIT]
                     || (s0_hdr_reg.payload_size == 32'd0);
    // A nonzero size passes only as exactly one page
    assign size_bad   = s0_hdr_reg.payload_size != 32'(PAGE_BYTES);
    assign end_addr   = 33'(s0_hdr_reg.target_addr) + 33'(s0_hdr_reg.payload_size);
    assign limit_addr = 33'(flash_base) + 33'(flash_bytes);
    assign range_bad  = (s0_hdr_reg.target_addr < flash_base) || (end_addr > limit_addr);
    assign family_bad = (s0_hdr_reg.family_id != 32'd0)
                     && (s0_hdr_reg.family_id != accepted_family);

    always_comb
    begin
        if (magic_bad)
        begin
            chk = CHK_MAGIC;
        end
        else if (skip)
        begin
            chk = CHK_SKIP;
        end
        else if (size_bad)
        begin
            chk = CHK_SIZE;
        end
        else if (range_bad)
        begin
            chk = CHK_RANGE;
        end
        else if (family_bad)
        begin
            chk = CHK_FAMILY;
        end
        else
        begin
            chk = CHK_OK;
        end
    end

    // Offset fits OFF_W bits whenever the range check passes
    assign off_full = s0_hdr_reg.target_addr - flash_base;
    assign offset   = off_full[OFF_W-1:0];
    assign pg_prod  = PROD_W'(offset) * PROD_W'(PG_MUL);
    assign sc_prod  = PROD_W'(offset) * PROD_W'(SC_MUL);

    // Control registers of both stages
    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (hdr_take)
        begin
            s0_valid_next = 1'b1;
        end
        else if (s0_adv)
        begin
            s0_valid_next = 1'b0;
        end
        s1_valid_next = s1_valid_reg;
        if (s0_adv)
        begin
            s1_valid_next = 1'b1;
        end
        else if (stat.take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (hdr_take)
        begin
            s0_hdr_reg <= hdr.data;
        end
        if (s0_adv)
        begin
            s1_end_reg     <= s0_hdr_reg.action;
            s1_chk_reg     <= chk;
            s1_nblocks_reg <= s0_hdr_reg.num_blocks;
            s1_offset_reg  <= offset;
            s1_qpage_reg   <= pg_prod[PG_S +: QP_W];
            s1_qsec_reg    <= sc_prod[SC_S +: QS_W];
        end
    end

    // Page alignment, sector range and sector base from the quotients
    assign page_base = OFF_W'(32'(s1_qpage_reg) * 32'(PAGE_BYTES));
    assign sec_wide  = 32'(s1_qsec_reg);

    assign s1_valid      = s1_valid_reg;
    assign s1_ctl        = '{is_end:    s1_end_reg,
                             chk:       s1_chk_reg,
                             align_ok:  page_base == s1_offset_reg,
                             sector_ok: sec_wide < 32'(SECTOR_COUNT)};
    assign s1_nblocks    = s1_nblocks_reg;
    assign s1_offset     = s1_offset_reg;
    assign s1_sector_off = OFF_W'(sec_wide * 32'(SECTOR_BYTES));
    assign s1_sector_idx = sec_wide[IDX_W-1:0];

endmodule

/* rtl/uf2bfs_seq.sv */
// Decision stage of the UF2 block flash sequencer: image state, erase map and result register.
// Depends on uf2bfs_pkg, uf2bfs_if and uf2bfs_ram; fed by uf2bfs_check.
`timescale 1ns / 1ps

module uf2bfs_seq
    import uf2bfs_pkg::*;
#(
    parameter int SECTOR_COUNT = 512,
    localparam int IDX_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  s1_ctl_t           s1_ctl,
    input  logic [31:0]       s1_nblocks,
    input  logic [OFF_W-1:0]  s1_offset,
    input  logic [OFF_W-1:0]  s1_sector_off,
    input  logic [IDX_W-1:0]  s1_sector_idx,
    output seq_stat_t         stat,
    uf2bfs_res_if.source      res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SECTOR_COUNT - 1);

    logic             s2_valid_reg, s2_valid_next;
    logic             s2_phase_reg, s2_phase_next;
    s1_ctl_t          s2_ctl_reg;
    logic [31:0]      s2_nblocks_reg;
    logic [OFF_W-1:0] s2_offset_reg;
    logic [OFF_W-1:0] s2_secoff_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [31:0]      exp_reg, exp_next;
    logic [15:0]      wc_reg, wc_next;
    logic             failed_reg, failed_next;
    logic             clr_reg, clr_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;

    res_t             res_now;
    logic [15:0]      wc_inc;
    logic             two_res, set_failed, do_erase, bump, take_exp;
    logic             out_free, s2_fire, s2_done, end_done, take;
    logic [0:0]       ram_rdata;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;

    // Erase map, one bit per sector
    uf2bfs_ram #(
        .WIDTH (1),
        .DEPTH (SECTOR_COUNT)
    ) u_erased_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (!clr_reg),
        .rd_en   (take),
        .rd_addr (s1_sector_idx),
        .rd_data (ram_rdata)
    );

    assign wc_inc = (wc_reg == 16'hFFFF) ? wc_reg : wc_reg + 16'd1;

    // Decide the result of the item in the decision stage
    always_comb
    begin
        res_now = '{command:        CMD_SKIPPED,
                    flash_offset:   '0,
                    error_code:     ERR_NONE,
                    blocks_written: wc_reg,
                    last:           1'b1};
        two_res    = 1'b0;
        set_failed = 1'b0;
        do_erase   = 1'b0;
        bump       = 1'b0;
        take_exp   = 1'b0;
        if (s2_phase_reg)
        begin
            res_now.command      = CMD_PROGRAM;
            res_now.flash_offset = s2_offset_reg[20:0];
        end
        else if (s2_ctl_reg.is_end)
        begin
            if (failed_reg)
            begin
                res_now.command = CMD_ERROR;
            end
            else if (wc_reg == 16'd0)
            begin
                res_now.command    = CMD_ERROR;
                res_now.error_code = ERR_NO_BLOCKS;
            end
            else if ((exp_reg != 32'd0) && (32'(wc_reg) != exp_reg))
            begin
                res_now.command    = CMD_ERROR;
                res_now.error_code = ERR_COUNT;
            end
            else
            begin
                res_now.command = CMD_IMAGE_OK;
            end
        end
        else if (failed_reg)
        begin
            res_now.command = CMD_IGNORED;
        end
        else
        begin
            case (s2_ctl_reg.chk)
                CHK_MAGIC:
                begin
                    res_now.command    = CMD_ERROR;
                    res_now.error_code = ERR_MAGIC;
                    set_failed         = 1'b1;
                end
                CHK_SKIP:
                begin
                    res_now.command = CMD_SKIPPED;
                end
                CHK_SIZE:
                begin
                    res_now.command    = CMD_ERROR;
                    res_now.error_code = ERR_SIZE;
                    set_failed         = 1'b1;
                end
                CHK_RANGE:
                begin
                    res_now.command    = CMD_ERROR;
                    res_now.error_code = ERR_RANGE;
                    set_failed         = 1'b1;
                end
                CHK_FAMILY:
                begin
                    res_now.command    = CMD_ERROR;
                    res_now.error_code = ERR_FAMILY;
                    set_failed         = 1'b1;
                end
                CHK_OK:
                begin
                    // Latch the announced count before the late checks
                    take_exp = (exp_reg == 32'd0) && (s2_nblocks_reg != 32'd0);
                    if (!s2_ctl_reg.align_ok)
                    begin
                        res_now.command    = CMD_ERROR;
                        res_now.error_code = ERR_ALIGN;
                        set_failed         = 1'b1;
                    end
                    else if (!s2_ctl_reg.sector_ok)
                    begin
                        res_now.command    = CMD_ERROR;
                        res_now.error_code = ERR_RANGE;
                        set_failed         = 1'b1;
                    end
                    else
                    begin
                        bump                   = 1'b1;
                        res_now.blocks_written = wc_inc;
                        if (!ram_rdata[0])
                        begin
                            do_erase             = 1'b1;
                            two_res              = 1'b1;
                            res_now.command      = CMD_ERASE;
                            res_now.flash_offset = s2_secoff_reg[20:0];
                            res_now.last         = 1'b0;
                        end
                        else
                        begin
                            res_now.command      = CMD_PROGRAM;
                            res_now.flash_offset = s2_offset_reg[20:0];
                        end
                    end
                end
                default:
                begin
                    res_now.command = CMD_SKIPPED;
                end
            endcase
        end
    end

    // Stage handshake; hold the next item back while the map is swept
    assign out_free = !out_valid_reg || res.ready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s2_done  = s2_fire && !two_res;
    assign end_done = s2_done && s2_ctl_reg.is_end;
    assign take     = s1_valid && !clr_reg
                   && (!s2_valid_reg || (s2_done && !s2_ctl_reg.is_end));

    // Map writes: sweep zeros, or mark a sector erased
    assign ram_wr_en   = clr_reg || (s2_fire && do_erase);
    assign ram_wr_addr = clr_reg ? clr_cnt_reg : s2_idx_reg;

    // Next values of control and state registers
    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        s2_phase_next  = s2_phase_reg;
        exp_next       = exp_reg;
        wc_next        = wc_reg;
        failed_next    = failed_reg;
        clr_next       = clr_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;

        if (s2_fire)
        begin
            s2_phase_next = two_res;
        end
        if (take)
        begin
            s2_valid_next = 1'b1;
            s2_phase_next = 1'b0;
        end
        else if (s2_done)
        begin
            s2_valid_next = 1'b0;
        end

        if (end_done)
        begin
            exp_next    = 32'd0;
            wc_next     = 16'd0;
            failed_next = 1'b0;
        end
        else if (s2_fire)
        begin
            if (take_exp)
            begin
                exp_next = s2_nblocks_reg;
            end
            if (bump)
            begin
                wc_next = wc_inc;
            end
            if (set_failed)
            begin
                failed_next = 1'b1;
            end
        end

        if (clr_reg)
        begin
            if (clr_cnt_reg == LAST_IDX)
            begin
                clr_next     = 1'b0;
                clr_cnt_next = '0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
        else if (end_done)
        begin
            clr_next     = 1'b1;
            clr_cnt_next = '0;
        end

        if (s2_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Reset starts with a sweep of the erase map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s2_phase_reg  <= 1'b0;
            exp_reg       <= 32'd0;
            wc_reg        <= 16'd0;
            failed_reg    <= 1'b0;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s2_phase_reg  <= s2_phase_next;
            exp_reg       <= exp_next;
            wc_reg        <= wc_next;
            failed_reg    <= failed_next;
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_ctl_reg     <= s1_ctl;
            s2_nblocks_reg <= s1_nblocks;
            s2_offset_reg  <= s1_offset;
            s2_secoff_reg  <= s1_sector_off;
            s2_idx_reg     <= s1_sector_idx;
        end
        if (s2_fire)
        begin
            out_reg <= res_now;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;
    assign stat      = '{take: take, clearing: clr_reg};

endmodule

/* rtl/uf2_block_flash_sequencer_core.sv */
// Top level of the UF2 block flash sequencer: config registers, check pipeline, sequencer.
// Depends on uf2bfs_pkg, uf2bfs_if, uf2bfs_check and uf2bfs_seq.
//
//   channel  modport  handshake          payload
//   hdr      sink     hdr.valid/ready    hdr_t: one block header or end-of-image item
//   res      source   res.valid/ready    res_t: one erase/program/status item
//   cfg      sink     cfg.valid/ready    register index and 32-bit write data
//
// An item passes an input register, a check stage, a decision stage and the result
// register, in that order, before its first result shows on res. One item per cycle is
// taken while res does not stall and no sweep runs; a block that erases a new sector holds
// the decision stage for its program item. After reset and after every end-of-image item
// the erase map is swept clear with hdr.ready low; cfg writes are always taken.
// A stalled res holds the result register and backs up through all stages.
`timescale 1ns / 1ps

module uf2_block_flash_sequencer_core
    import uf2bfs_pkg::*;
#(
    parameter int SECTOR_COUNT = 512,
    parameter int SECTOR_BYTES = 4096,
    parameter int PAGE_BYTES   = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    uf2bfs_hdr_if.sink    hdr,
    uf2bfs_res_if.source  res,
    uf2bfs_cfg_if.sink    cfg
);

    localparam int IDX_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

    logic [31:0]      flash_base_reg, flash_base_next;
    logic [OFF_W-1:0] flash_bytes_reg, flash_bytes_next;
    logic [31:0]      accepted_family_reg, accepted_family_next;

    seq_stat_t        stat;
    logic             s1_valid;
    s1_ctl_t          s1_ctl;
    logic [31:0]      s1_nblocks;
    logic [OFF_W-1:0] s1_offset;
    logic [OFF_W-1:0] s1_sector_off;
    logic [IDX_W-1:0] s1_sector_idx;

    // Config writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        flash_base_next      = flash_base_reg;
        flash_bytes_next     = flash_bytes_reg;
        accepted_family_next = accepted_family_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FLASH_BASE:      flash_base_next      = cfg.data;
                CFG_FLASH_BYTES:     flash_bytes_next     = cfg.data[OFF_W-1:0];
                CFG_ACCEPTED_FAMILY: accepted_family_next = cfg.data;
                default:             flash_base_next      = flash_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg      <= FLASH_BASE_RST;
            flash_bytes_reg     <= FLASH_BYTES_RST;
            accepted_family_reg <= ACCEPTED_FAMILY_RST;
        end
        else
        begin
            flash_base_reg      <= flash_base_next;
            flash_bytes_reg     <= flash_bytes_next;
            accepted_family_reg <= accepted_family_next;
        end
    end

    uf2bfs_check #(
        .SECTOR_COUNT (SECTOR_COUNT),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .hdr             (hdr),
        .flash_base      (flash_base_reg),
        .flash_bytes     (flash_bytes_reg),
        .accepted_family (accepted_family_reg),
        .stat            (stat),
        .s1_valid        (s1_valid),
        .s1_ctl          (s1_ctl),
        .s1_nblocks      (s1_nblocks),
        .s1_offset       (s1_offset),
        .s1_sector_off   (s1_sector_off),
        .s1_sector_idx   (s1_sector_idx)
    );

    uf2bfs_seq #(
        .SECTOR_COUNT (SECTOR_COUNT)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_ctl        (s1_ctl),
        .s1_nblocks    (s1_nblocks),
        .s1_offset     (s1_offset),
        .s1_sector_off (s1_sector_off),
        .s1_sector_idx (s1_sector_idx),
        .stat          (stat),
        .res           (res)
    );

    // No header item enters during the erase-map sweep
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !(hdr.valid && hdr.ready))
        else $error("header item accepted during erase-map sweep");

    // Only an erase item leaves its header unfinished
    a_open_is_erase: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.last) |-> (res.data.command == CMD_ERASE))
        else $error("non-final result item that is not an erase");

    // A taken erase item is followed at once by its program item
    a_erase_then_program: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.data.command == CMD_ERASE)
        |=> (res.valid && res.data.command == CMD_PROGRAM))
        else $error("erase item not followed by program item");

    // Error codes ride only on error items
    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.error_code != ERR_NONE) |-> (res.data.command == CMD_ERROR))
        else $error("error code on a non-error result item");

endmodule

/* tb/tb_top.sv */
// Testbench for uf2_block_flash_sequencer_core: streams UF2 block headers and end-of-image
// items, predicts the erase/program/status commands and checks every result item in order.
// Depends on uf2bfs_pkg, the uf2bfs_if interfaces and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
    import uf2bfs_pkg::*;

    localparam int unsigned SECTOR_COUNT  = 512;
    localparam int unsigned SECTOR_BYTES  = 4096;
    localparam int unsigned PAGE_BYTES    = 256;
    localparam int unsigned MAX_PAYLOAD   = 476;
    localparam logic [31:0] SKIP_FLAGS    = (32'd1 << FLAG_NOT_MAIN_BIT)
                                          | (32'd1 << FLAG_CONTAINER_BIT);
    localparam int unsigned RANDOM_ITEMS  = 650;
    localparam int unsigned PHASE_ITEMS   = 110;
    localparam int unsigned BURST_BLOCKS  = 48;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 24;
    localparam int unsigned REPORT_CAP    = 50;

    typedef enum logic [1:0] {OP_HDR, OP_CFG, OP_SYNC} op_kind_t;

    typedef struct {
        op_kind_t    kind;
        hdr_t        hdr;
        cfg_idx_t    idx;
        logic [31:0] val;
        bit          burst;
    } op_t;

    logic clk;
    logic rst_n;

    uf2bfs_hdr_if hdr_ch ();
    uf2bfs_res_if res_ch ();
    uf2bfs_cfg_if cfg_ch ();

    uf2_block_flash_sequencer_core #(
        .SECTOR_COUNT (SECTOR_COUNT),
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Predicted block state and register copies
    logic [31:0]             mdl_base         = FLASH_BASE_RST;
    logic [21:0]             mdl_bytes        = FLASH_BYTES_RST;
    logic [31:0]             mdl_family       = ACCEPTED_FAMILY_RST;
    logic [SECTOR_COUNT-1:0] erased_sectors   = '0;
    logic [31:0]             announced_count  = '0;
    logic [15:0]             programmed_count = '0;
    bit                      image_failed     = 1'b0;

    // Register values as the stimulus plans them
    logic [31:0] plan_base   = FLASH_BASE_RST;
    logic [31:0] plan_bytes  = {10'd0, FLASH_BYTES_RST};
    logic [31:0] plan_family = ACCEPTED_FAMILY_RST;
    int unsigned hot_sector [4];

    op_t         item_feed [$];
    res_t        expected_cmds [$];
    int unsigned mismatches = 0;

    int unsigned gap_left;
    int unsigned settle_left;
    int unsigned stall_left;
    int unsigned hdr_calm = 0;
    int unsigned res_calm = 0;
    bit          sync_armed;
    bit          burst_mode;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset, with every block input at a known value from time zero
    initial
    begin
        rst_n        = 1'b0;
        hdr_ch.valid = 1'b0;
        hdr_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        res_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Idle length: mostly short, a few long, with calm stretches of none
    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0)
            calm = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ---------------------------------------------------------------- prediction

    function automatic void expect_cmd(cmd_t c, logic [20:0] off, err_t e, logic fin);
        res_t r;
        r.command        = c;
        r.flash_offset   = off;
        r.error_code     = e;
        r.blocks_written = programmed_count;
        r.last           = fin;
        expected_cmds.push_back(r);
    endfunction

    function automatic void reject_block(err_t e);
        image_failed = 1'b1;
        expect_cmd(CMD_ERROR, '0, e, 1'b1);
    endfunction

    function automatic void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            CFG_FLASH_BASE:      mdl_base = val;
            CFG_FLASH_BYTES:     mdl_bytes = val[21:0];
            CFG_ACCEPTED_FAMILY: mdl_family = val;
            default: ;
        endcase
    endfunction

    // Work out the commands that one accepted header or end item causes
    function automatic void sequence_block(hdr_t h);
        logic [32:0] reach;
        logic [32:0] window_end;
        logic [31:0] offset;
        logic [31:0] sector;
        logic [31:0] sector_off;
        reach      = {1'b0, h.target_addr} + {1'b0, h.payload_size};
        window_end = {1'b0, mdl_base} + {11'd0, mdl_bytes};
        offset     = h.target_addr - mdl_base;
        sector     = offset / SECTOR_BYTES;
        sector_off = sector * SECTOR_BYTES;
        if (h.action)
        begin
            // End of image: report the verdict, then forget the image
            if (image_failed)
                expect_cmd(CMD_ERROR, '0, ERR_NONE, 1'b1);
            else if (programmed_count == 16'd0)
                expect_cmd(CMD_ERROR, '0, ERR_NO_BLOCKS, 1'b1);
            else if (announced_count != 0 && {16'd0, programmed_count} != announced_count)
                expect_cmd(CMD_ERROR, '0, ERR_COUNT, 1'b1);
            else
                expect_cmd(CMD_IMAGE_OK, '0, ERR_NONE, 1'b1);
            erased_sectors   = '0;
            announced_count  = '0;
            programmed_count = '0;
            image_failed     = 1'b0;
        end
        else if (image_failed)
            expect_cmd(CMD_IGNORED, '0, ERR_NONE, 1'b1);
        else if (h.magic_start0 != MAGIC_START0 || h.magic_start1 != MAGIC_START1
                 || h.magic_end != MAGIC_END)
            reject_block(ERR_MAGIC);
        else if ((h.flags & SKIP_FLAGS) != 0 || h.payload_size == 0)
            expect_cmd(CMD_SKIPPED, '0, ERR_NONE, 1'b1);
        else if (h.payload_size > MAX_PAYLOAD || h.payload_size % PAGE_BYTES != 0
                 || h.payload_size > PAGE_BYTES)
            reject_block(ERR_SIZE);
        else if (h.target_addr < mdl_base || reach > window_end)
            reject_block(ERR_RANGE);
        else if (h.family_id != 0 && h.family_id != mdl_family)
            reject_block(ERR_FAMILY);
        else
        begin
            // The announced count is latched before the alignment check
            if (announced_count == 0)
                announced_count = h.num_blocks;
            if (offset % PAGE_BYTES != 0)
                reject_block(ERR_ALIGN);
            else if (sector >= SECTOR_COUNT)
                reject_block(ERR_RANGE);
            else
            begin
                if (programmed_count != 16'hFFFF)
                    programmed_count = programmed_count + 16'd1;
                if (!erased_sectors[sector])
                begin
                    erased_sectors[sector] = 1'b1;
                    expect_cmd(CMD_ERASE, sector_off[20:0], ERR_NONE, 1'b0);
                end
                expect_cmd(CMD_PROGRAM, offset[20:0], ERR_NONE, 1'b1);
            end
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic hdr_t noise_hdr();
        hdr_t h;
        h.action       = 1'b0;
        h.magic_start0 = $urandom;
        h.magic_start1 = $urandom;
        h.magic_end    = $urandom;
        h.flags        = $urandom;
        h.target_addr  = $urandom;
        h.payload_size = $urandom;
        h.num_blocks   = $urandom;
        h.family_id    = $urandom;
        return h;
    endfunction

    function automatic hdr_t good_block(int unsigned page, logic [31:0] count);
        hdr_t h;
        h              = noise_hdr();
        h.magic_start0 = MAGIC_START0;
        h.magic_start1 = MAGIC_START1;
        h.magic_end    = MAGIC_END;
        h.flags        = h.flags & ~SKIP_FLAGS;
        h.target_addr  = plan_base + page * PAGE_BYTES;
        h.payload_size = PAGE_BYTES;
        h.num_blocks   = count;
        h.family_id    = $urandom_range(0, 1) ? 32'd0 : plan_family;
        return h;
    endfunction

    // Page inside the window, half the time in one of a few hot sectors
    function automatic int unsigned pick_page();
        int unsigned pages;
        int unsigned sec_pages;
        pages     = plan_bytes / PAGE_BYTES;
        sec_pages = SECTOR_BYTES / PAGE_BYTES;
        if ($urandom_range(0, 1))
            return (hot_sector[$urandom_range(0, 3)] * sec_pages
                    + $urandom_range(0, sec_pages - 1)) % pages;
        return $urandom_range(0, pages - 1);
    endfunction

    // Spoil one aspect of an otherwise valid block, or replace it with noise
    function automatic hdr_t broken_block(hdr_t h);
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 2))
                    0:       h.magic_start0 ^= ($urandom | 32'd1);
                    1:       h.magic_start1 ^= ($urandom | 32'd1);
                    default: h.magic_end ^= ($urandom | 32'd1);
                endcase
            end
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       h.payload_size = $urandom;
                    1:       h.payload_size = 2 * PAGE_BYTES;
                    2:       h.payload_size = MAX_PAYLOAD;
                    3:       h.payload_size = $urandom_range(1, PAGE_BYTES - 1);
                    default: h.payload_size = PAGE_BYTES + $urandom_range(1, 219);
                endcase
            end
            2: h.target_addr += $urandom_range(1, PAGE_BYTES - 1);
            3:
            begin
                if ($urandom_range(0, 1) && plan_base >= 32'd4096)
                    h.target_addr = plan_base - PAGE_BYTES * $urandom_range(1, 16);
                else
                    h.target_addr = plan_base + plan_bytes - $urandom_range(0, PAGE_BYTES - 1);
            end
            4: h.family_id = plan_family ^ ($urandom | 32'd1);
            default: h = noise_hdr();
        endcase
        return h;
    endfunction

    function automatic void queue_block(hdr_t h, bit burst = 1'b0);
        op_t op;
        op.kind  = OP_HDR;
        op.hdr   = h;
        op.idx   = CFG_FLASH_BASE;
        op.val   = '0;
        op.burst = burst;
        item_feed.push_back(op);
    endfunction

    function automatic void queue_end(bit burst = 1'b0);
        hdr_t h;
        h        = noise_hdr();
        h.action = 1'b1;
        queue_block(h, burst);
    endfunction

    function automatic void queue_reg(cfg_idx_t idx, logic [31:0] val);
        op_t op;
        op.kind  = OP_CFG;
        op.hdr   = '0;
        op.idx   = idx;
        op.val   = val;
        op.burst = 1'b0;
        item_feed.push_back(op);
        case (idx)
            CFG_FLASH_BASE:  plan_base = val;
            CFG_FLASH_BYTES: plan_bytes = {10'd0, val[21:0]};
            default:         plan_family = val;
        endcase
    endfunction

    function automatic void queue_sync();
        op_t op;
        op.kind  = OP_SYNC;
        op.hdr   = '0;
        op.idx   = CFG_FLASH_BASE;
        op.val   = '0;
        op.burst = 1'b0;
        item_feed.push_back(op);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : feed_items
        op_t  op;
        logic hdr_up;
        logic cfg_up;
        if (!rst_n)
        begin
            hdr_ch.valid <= 1'b0;
            hdr_ch.data  <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data  <= '0;
            burst_mode   <= 1'b0;
            gap_left     = 0;
            settle_left  = 0;
            sync_armed   = 1'b0;
        end
        else
        begin
            hdr_up = hdr_ch.valid;
            cfg_up = cfg_ch.valid;
            // Retire accepted items into the predictor
            if (hdr_up && hdr_ch.ready)
            begin
                sequence_block(hdr_ch.data);
                hdr_up = 1'b0;
            end
            if (cfg_up && cfg_ch.ready)
            begin
                write_reg(cfg_ch.index, cfg_ch.data);
                cfg_up = 1'b0;
            end
            // Offer the next item once both channels are free
            if (!hdr_up && !cfg_up && item_feed.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    op = item_feed[0];
                    case (op.kind)
                        OP_SYNC:
                        begin
                            // Hold until every result is out, then let the block settle
                            if (!sync_armed || expected_cmds.size() != 0)
                            begin
                                sync_armed  = 1'b1;
                                settle_left = SETTLE_CYCLES;
                            end
                            else if (settle_left > 0)
                                settle_left--;
                            else
                            begin
                                sync_armed = 1'b0;
                                void'(item_feed.pop_front());
                            end
                        end
                        OP_HDR:
                        begin
                            hdr_up = 1'b1;
                            hdr_ch.data <= op.hdr;
                            burst_mode  <= op.burst;
                            gap_left = op.burst ? 0 : idle_len(hdr_calm);
                            void'(item_feed.pop_front());
                        end
                        default:
                        begin
                            cfg_up = 1'b1;
                            cfg_ch.index <= op.idx;
                            cfg_ch.data  <= op.val;
                            gap_left = idle_len(hdr_calm);
                            void'(item_feed.pop_front());
                        end
                    endcase
                end
            end
            hdr_ch.valid <= hdr_up;
            cfg_ch.valid <= cfg_up;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk or negedge rst_n)
    begin : watch_results
        res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            // Compare each accepted result item with the oldest expectation
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: unexpected result item, expected none,",
                                 $time,
                                 " got cmd=%0d off=%h err=%0d cnt=%0d last=%0d",
                                 res_ch.data.command, res_ch.data.flash_offset,
                                 res_ch.data.error_code, res_ch.data.blocks_written,
                                 res_ch.data.last);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (res_ch.data.command !== want.command
                        || res_ch.data.flash_offset !== want.flash_offset
                        || res_ch.data.error_code !== want.error_code
                        || res_ch.data.blocks_written !== want.blocks_written
                        || res_ch.data.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: result mismatch,", $time,
                                     " expected cmd=%0d off=%h err=%0d cnt=%0d last=%0d,",
                                     want.command, want.flash_offset, want.error_code,
                                     want.blocks_written, want.last,
                                     " got cmd=%0d off=%h err=%0d cnt=%0d last=%0d",
                                     res_ch.data.command, res_ch.data.flash_offset,
                                     res_ch.data.error_code, res_ch.data.blocks_written,
                                     res_ch.data.last);
                    end
                end
            end
            // Stall the result side at random, never during a burst
            if (burst_mode)
            begin
                stall_left = 0;
                res_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = idle_len(res_calm);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus and end

    initial
    begin : build_stimulus
        hdr_t        h;
        int unsigned random_items;
        int unsigned next_phase;
        int unsigned setting;
        int unsigned n;
        int unsigned stop_at;
        int unsigned bad_at;
        int unsigned span;
        int unsigned last_page;
        logic [31:0] announce;
        logic [31:0] base;
        logic [31:0] bytes;
        logic [31:0] family;

        // Directed part at the reset register values
        last_page = plan_bytes / PAGE_BYTES - 1;
        queue_end();                                  // image with no blocks
        queue_block(good_block(0, 0));
        queue_block(good_block(1, 3));                // first nonzero count wins
        h = good_block(last_page, 7);
        h.family_id = plan_family;
        queue_block(h);
        h = good_block(2, 0);
        h.flags |= 32'd1 << FLAG_NOT_MAIN_BIT;
        queue_block(h);
        h = good_block(2, 0);
        h.flags |= 32'd1 << FLAG_CONTAINER_BIT;
        queue_block(h);
        h = good_block(2, 0);
        h.payload_size = 0;
        queue_block(h);
        queue_end();                                  // count matches
        queue_block(good_block(0, 5));                // sector erased again
        queue_end();                                  // count mismatch
        h = good_block(16, 0);
        h.family_id = 0;
        queue_block(h);
        queue_end();                                  // no count announced
        h = good_block(0, 1);
        h.magic_end = ~MAGIC_END;
        queue_block(h);
        queue_block(good_block(1, 1));                // ignored after failure
        queue_end();                                  // failure already reported
        h = good_block(0, 1);
        h.payload_size = 2 * PAGE_BYTES;
        queue_block(h);
        queue_end();
        h = good_block(0, 1);
        h.target_addr = plan_base - PAGE_BYTES;
        queue_block(h);
        queue_end();
        h = good_block(0, 1);
        h.target_addr = plan_base + plan_bytes;
        queue_block(h);
        queue_end();
        h = good_block(0, 1);
        h.family_id = plan_family + 1;
        queue_block(h);
        queue_end();
        h = good_block(0, 1);
        h.target_addr += 4;
        queue_block(h);
        queue_end();

        // Random images, with a new register setting every phase
        random_items = 0;
        next_phase   = 0;
        setting      = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= next_phase)
            begin
                setting++;
                next_phase += PHASE_ITEMS;
                case (setting % 6)
                    0:
                    begin
                        base   = FLASH_BASE_RST;
                        bytes  = {10'd0, FLASH_BYTES_RST};
                        family = ACCEPTED_FAMILY_RST;
                    end
                    1:
                    begin
                        base   = 32'd0;
                        bytes  = SECTOR_BYTES;
                        family = 32'd0;
                    end
                    2:
                    begin
                        base   = 32'hFFFF_F000;
                        bytes  = SECTOR_BYTES;
                        family = 32'hFFFF_FFFF;
                    end
                    3:
                    begin
                        bytes  = SECTOR_BYTES * SECTOR_COUNT;
                        base   = $urandom & 32'hFFFF_FF00;
                        family = $urandom;
                        if (base > ~bytes)
                            base = base - bytes;
                    end
                    default:
                    begin
                        bytes  = SECTOR_BYTES * $urandom_range(1, SECTOR_COUNT);
                        base   = $urandom;
                        family = $urandom;
                        if (base > ~bytes)
                            base = base - bytes;
                    end
                endcase
                queue_sync();
                queue_reg(CFG_FLASH_BASE, base);
                queue_reg(CFG_FLASH_BYTES, bytes);
                queue_reg(CFG_ACCEPTED_FAMILY, family);
                foreach (hot_sector[i])
                    hot_sector[i] = $urandom_range(0, plan_bytes / SECTOR_BYTES - 1);
            end

            n = $urandom_range(0, 99);
            if (n < 75)
            begin
                // Well-formed image, sometimes spoiled by one bad block
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
                bad_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
                stop_at = (bad_at + 3 < n) ? bad_at + 3 : n;
                case ($urandom_range(0, 5))
                    0:       announce = 0;
                    1:       announce = n - 1;
                    2:       announce = n + 1;
                    3:       announce = $urandom;
                    default: announce = n;
                endcase
                for (int unsigned i = 0; i < stop_at; i++)
                begin
                    h = good_block(pick_page(),
                                   (i == 0) ? announce
                                            : ($urandom_range(0, 1) ? announce : $urandom));
                    if (i == bad_at)
                        h = broken_block(h);
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       h.flags |= 32'd1 << FLAG_NOT_MAIN_BIT;
                            1:       h.flags |= 32'd1 << FLAG_CONTAINER_BIT;
                            default: h.payload_size = 0;
                        endcase
                    end
                    queue_block(h);
                    if (i <= bad_at)
                        random_items++;
                end
            end
            else if (n < 93)
            begin
                // Noise blocks
                n = $urandom_range(1, 4);
                repeat (n) queue_block(noise_hdr());
                random_items += n;
            end
            queue_end();
            random_items++;
        end

        // One image at full rate, with the result side never stalled
        span = plan_bytes / PAGE_BYTES;
        if (span > 64)
            span = 64;
        for (int unsigned i = 0; i < BURST_BLOCKS; i++)
            queue_block(good_block(i % span, (i == 0) ? BURST_BLOCKS : 32'd0), 1'b1);
        queue_end(1'b1);

        // Wait for the last item and its results, then a little longer
        @(posedge rst_n);
        do
            @(posedge clk);
        while (item_feed.size() != 0 || hdr_ch.valid || cfg_ch.valid
               || expected_cmds.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/uf2bfs_pkg.sv
rtl/uf2bfs_if.sv
rtl/uf2bfs_ram.sv
rtl/uf2bfs_check.sv
rtl/uf2bfs_seq.sv
rtl/uf2_block_flash_sequencer_core.sv
tb/tb_top.sv
